FILE: hdl/ipc_pkg.sv
// Shared types, constants and the neighborhood test of the isolated pixel counter.
`default_nettype none

package ipc_pkg;

   // Width of the image size registers.
   localparam int CFG_W = 11;
   // Width of the isolated pixel count and its saturation value.
   localparam int COUNT_W = 21;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   // Widths of the stream data buses, padded to whole bytes.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   // Configuration bus widths.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Default size limits of the line stores and the row counter.
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Image size after reset.
   localparam logic [CFG_W-1:0] RESET_DIM = 11'd12;

   // Register indexes, taken from byte address bit 2.
   localparam logic REG_IMAGE_WIDTH = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // 3x3 window: bit (row*3 + col), row 0 is the oldest line, col 0 the oldest column.
   typedef logic [8:0] window_type;

   // Position of the word held in the decision stage.
   typedef struct packed {
      logic col_ge1;
      logic col_ge2;
      logic row_ge1;
      logic row_ge2;
      logic last_col;
      logic last_row;
   } pos_flags_type;

   // Looks at the window shifted by dr rows and dc columns, with the top row or the
   // left column dropped where they lie outside the frame. True when the center is
   // set and all eight neighbors are clear.
   function automatic logic is_isolated(window_type win, logic dr, logic dc,
                                        logic top_ok, logic left_ok);
      window_type w;
      int sr;
      int sc;
      w = '0;
      for (int nr = 0; nr < 3; nr++) begin
         for (int nc = 0; nc < 3; nc++) begin
            sr = nr + int'(dr);
            sc = nc + int'(dc);
            if (sr <= 2 && sc <= 2 && (nr != 0 || top_ok) && (nc != 0 || left_ok)) begin
               w[nr*3+nc] = win[sr*3+sc];
            end
         end
      end
      return w[4] && ((w & 9'h1EF) == 9'h000);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/ipc_line_mem.sv
// Line store: one synchronous memory holding the two previous image rows per column.
`default_nettype none

module ipc_line_mem #(
   parameter int DEPTH = ipc_pkg::DEF_MAX_WIDTH,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = 2
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/isolated_pixel_counter.sv
// Top level of the isolated pixel counter: counters, line store, window and result register.
`default_nettype none

// Counts, per frame, the set pixels of a binary image whose 8-connected neighbors
// inside the frame are all clear; neighbors beyond the frame edges count as clear.
// Pixels arrive in raster order, one per word on the req_ stream, and the block takes
// one pixel every clock cycle while it is not stalled. Each pixel does one read and one
// write-back of a single 2-bit-wide line store (the two rows above, per column): the
// read is issued when the word is accepted and the write-back happens from the decision
// stage, when the window and the count are updated. Consecutive pixels always touch
// different columns, so no forwarding is needed. The count result for a frame
// becomes valid on the rsp_ stream when its last pixel leaves the decision stage, and
// is held until taken. Input is stalled only while a second frame result is ready
// before the first one has been taken. Image width and height are set through the
// csr_ port (byte address 0 and 4, both 12 after reset); values below 2 are used as 2
// and values above MAX_WIDTH or MAX_HEIGHT as those limits. The line store needs no
// clearing after reset, since entries that were never written are only read where the
// frame edge masks them. The count saturates at its all-ones value.
module isolated_pixel_counter #(
   parameter int MAX_WIDTH = ipc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ipc_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Pixel stream.
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [ipc_pkg::REQ_DATA_W-1:0]  req_tdata,  // [0] pixel, rest zero
   // Result stream.
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [ipc_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [20:0] isolated_count
   // Configuration port.
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ipc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ipc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [ipc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                            csr_pready
);

   localparam int CFG_W = ipc_pkg::CFG_W;
   localparam int COUNT_W = ipc_pkg::COUNT_W;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   // Compare widths that hold the column or row index, the register and the limit.
   localparam int WCMP_W = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
   localparam int HCMP_W = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;

   // Configuration registers.
   logic [CFG_W-1:0] cfg_width_ff, cfg_width_in;
   logic [CFG_W-1:0] cfg_height_ff, cfg_height_in;
   logic             csr_write;

   // Position counters of the next pixel to arrive.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WCMP_W-1:0] last_col_idx;
   logic [HCMP_W-1:0] last_row_idx;
   ipc_pkg::pos_flags_type pos_flags;

   // Decision stage, loaded when a pixel is accepted.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_pixel_ff, s1_pixel_in;
   logic [COL_W-1:0]       s1_addr_ff, s1_addr_in;
   ipc_pkg::pos_flags_type s1_flags_ff, s1_flags_in;

   // Window, count and result register.
   ipc_pkg::window_type window_ff, window_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic accept;
   logic advance;
   logic stall;
   logic frame_end;
   logic [1:0] line_rd;
   ipc_pkg::window_type win_next;
   logic [2:0] add_n;
   logic [COUNT_W:0] count_sum;
   logic [COUNT_W-1:0] count_sat;

   // ---------------------------------------------------------------- configuration
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_width_in = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            ipc_pkg::REG_IMAGE_WIDTH: cfg_width_in = csr_pwdata[CFG_W-1:0];
            ipc_pkg::REG_IMAGE_HEIGHT: cfg_height_in = csr_pwdata[CFG_W-1:0];
            default: cfg_width_in = cfg_width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         ipc_pkg::REG_IMAGE_WIDTH: csr_prdata = ipc_pkg::CSR_DATA_W'(cfg_width_ff);
         ipc_pkg::REG_IMAGE_HEIGHT: csr_prdata = ipc_pkg::CSR_DATA_W'(cfg_height_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff <= ipc_pkg::RESET_DIM;
         cfg_height_ff <= ipc_pkg::RESET_DIM;
      end else begin
         cfg_width_ff <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
      end
   end

   // ---------------------------------------------------------------- position
   // Index of the last column and row after clamping the registers to the legal range.
   always_comb begin
      if (cfg_width_ff < CFG_W'(2)) begin
         last_col_idx = WCMP_W'(1);
      end else if (WCMP_W'(cfg_width_ff) > WCMP_W'(MAX_WIDTH)) begin
         last_col_idx = WCMP_W'(MAX_WIDTH - 1);
      end else begin
         last_col_idx = WCMP_W'(cfg_width_ff) - WCMP_W'(1);
      end
      if (cfg_height_ff < CFG_W'(2)) begin
         last_row_idx = HCMP_W'(1);
      end else if (HCMP_W'(cfg_height_ff) > HCMP_W'(MAX_HEIGHT)) begin
         last_row_idx = HCMP_W'(MAX_HEIGHT - 1);
      end else begin
         last_row_idx = HCMP_W'(cfg_height_ff) - HCMP_W'(1);
      end
   end

   always_comb begin
      pos_flags.col_ge1 = col_ff != '0;
      pos_flags.col_ge2 = col_ff > COL_W'(1);
      pos_flags.row_ge1 = row_ff != '0;
      pos_flags.row_ge2 = row_ff > ROW_W'(1);
      pos_flags.last_col = WCMP_W'(col_ff) >= last_col_idx;
      pos_flags.last_row = HCMP_W'(row_ff) >= last_row_idx;
   end

   // A second frame result must wait while the first one has not been taken.
   assign frame_end = s1_flags_ff.last_col && s1_flags_ff.last_row;
   assign stall = s1_valid_ff && frame_end && rsp_valid_ff && !rsp_tready;
   assign advance = s1_valid_ff && !stall;
   assign req_tready = !stall;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (pos_flags.last_col) begin
            col_in = '0;
            row_in = pos_flags.last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- line store
   // Bit 1 holds the row two above, bit 0 the row just above.
   ipc_line_mem #(
      .DEPTH (MAX_WIDTH),
      .ADDR_W(COL_W),
      .DATA_W(2)
   ) u_line_mem (
      .clock  (clock),
      .wr_en  (advance),
      .wr_addr(s1_addr_ff),
      .wr_data({line_rd[0], s1_pixel_ff}),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(line_rd)
   );

   // ---------------------------------------------------------------- decision stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pixel_in = s1_pixel_ff;
      s1_addr_in = s1_addr_ff;
      s1_flags_in = s1_flags_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_pixel_in = req_tdata[0];
         s1_addr_in = col_ff;
         s1_flags_in = pos_flags;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff <= s1_pixel_in;
      s1_addr_ff <= s1_addr_in;
      s1_flags_ff <= s1_flags_in;
   end

   // The window shifts one column older; the new column enters at column 2.
   assign win_next = ((window_ff >> 1) & 9'h0DB)
                   | {s1_pixel_ff, 2'b00, line_rd[0], 2'b00, line_rd[1], 2'b00};

   // The pixel one row and one column back is decided on every pixel past the first row
   // and column. At the end of a row the pixel above the newest one is decided as well,
   // and in the last row the pixels of that row itself are decided too.
   always_comb begin
      logic d0, d1, d2, d3;
      d0 = s1_flags_ff.row_ge1 && s1_flags_ff.col_ge1
         && ipc_pkg::is_isolated(win_next, 1'b0, 1'b0,
                                 s1_flags_ff.row_ge2, s1_flags_ff.col_ge2);
      d1 = s1_flags_ff.row_ge1 && s1_flags_ff.col_ge1 && s1_flags_ff.last_col
         && ipc_pkg::is_isolated(win_next, 1'b0, 1'b1, s1_flags_ff.row_ge2, 1'b1);
      d2 = s1_flags_ff.last_row && s1_flags_ff.col_ge1
         && ipc_pkg::is_isolated(win_next, 1'b1, 1'b0, 1'b1, s1_flags_ff.col_ge2);
      d3 = s1_flags_ff.last_row && s1_flags_ff.col_ge1 && s1_flags_ff.last_col
         && ipc_pkg::is_isolated(win_next, 1'b1, 1'b1, 1'b1, 1'b1);
      add_n = 3'(d0) + 3'(d1) + 3'(d2) + 3'(d3);
   end

   assign count_sum = (COUNT_W+1)'(count_ff) + (COUNT_W+1)'(add_n);
   assign count_sat = (count_sum > (COUNT_W+1)'(ipc_pkg::COUNT_MAX))
                    ? ipc_pkg::COUNT_MAX : count_sum[COUNT_W-1:0];

   always_comb begin
      window_in = window_ff;
      count_in = count_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         if (frame_end) begin
            window_in = '0;
            count_in = '0;
            rsp_count_in = count_sat;
            rsp_valid_in = 1'b1;
         end else begin
            window_in = win_next;
            count_in = count_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = ipc_pkg::RSP_DATA_W'(rsp_count_ff);

endmodule

`default_nettype wire

FILE: hdl/ipc_checker.sv
// Port-level checks of the isolated pixel counter and their binding to the top level.
`default_nettype none

module ipc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ipc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // A result word waiting to be taken keeps its count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A new result follows the acceptance of a pixel.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a preceding pixel");

   // The padding above the count stays clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[ipc_pkg::RSP_DATA_W-1:ipc_pkg::COUNT_W] == '0)
      else $error("result padding not zero");

endmodule

bind isolated_pixel_counter ipc_checker u_ipc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire
